@@ hdl/plst_pkg.sv @@
// ----------------------------------------------------------------------------
// plst_pkg: shared types and constants of the positional list store
// Request and result layouts, operation and status codes, store geometry.
// ----------------------------------------------------------------------------
package plst_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 9;
    localparam int CNT_W  = 9;
    localparam int DATA_W = 32;
    localparam int CMP_W  = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

    localparam logic [1:0] FN_GET = 2'd0;
    localparam logic [1:0] FN_INS = 2'd1;
    localparam logic [1:0] FN_DEL = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]               func;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [1:0]               status;
        logic [CNT_W-1:0]         count;
    } t_rsp;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
    } t_ram_cmd;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_FETCH = 5'b00100,
        S_MOVE  = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

endpackage

@@ hdl/positional_list_store_core.sv @@
// ----------------------------------------------------------------------------
// positional_list_store_core: ordered store of signed 32-bit elements
// Get, insert and delete by 1-based position over a 256-entry memory.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a rising edge where start is high and busy is low.
// It carries the operation code, a 1-based position and, for an insert, the
// value to place. Every request yields exactly one result, shown on o_rsp
// for a single cycle while o_done is high; the receiver must take it then,
// since it cannot hold results off.
// A get passes the check and fetch states before it answers. Any request that
// fails (bad position, full store, unused operation code) is settled in the
// check state and answers from there. An insert passes the check, move and
// fin states, a delete the check, fetch, move and fin states; the move state
// walks the shift: each moved element needs one read and one write of the
// single element memory, and those are overlapped so one element moves per
// cycle.
// busy stays high from the accepting edge until the result shows; the
// next request may be taken in the very cycle the result is on the ports.
// Reset empties the store (length zero); the memory itself is not cleared,
// since entries beyond the length are never read.
// ----------------------------------------------------------------------------
module positional_list_store_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  plst_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output plst_pkg::t_rsp o_rsp
);
    import plst_pkg::*;

    t_ram_cmd          ram_cmd;
    logic [DATA_W-1:0] ram_rdata;

    // Sequencer: position checks, shift walk and the result register.
    plst_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_req     (i_req),
        .busy      (busy),
        .o_done    (o_done),
        .o_rsp     (o_rsp),
        .o_ram_cmd (ram_cmd),
        .i_rdata   (ram_rdata)
    );

    // Element memory with registered read data.
    plst_ram u_ram (
        .i_clk   (i_clk),
        .i_cmd   (ram_cmd),
        .o_rdata (ram_rdata)
    );

    // The result cycle is always an idle cycle of the sequencer.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while a request is still in work");

    // An accepted request keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start work");

    // The shift never reads and writes the same entry in one cycle.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_cmd.we && ram_cmd.re) |-> (ram_cmd.waddr != ram_cmd.raddr))
        else $error("read and write to the same entry in one cycle");

    // Failed requests return zero data.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status != ST_OK)) |-> (o_rsp.data == '0))
        else $error("failed request returned nonzero data");

endmodule

@@ hdl/plst_ram.sv @@
// ----------------------------------------------------------------------------
// plst_ram: element storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module plst_ram (
    input  logic                              i_clk,
    input  plst_pkg::t_ram_cmd                i_cmd,
    output logic [plst_pkg::DATA_W-1:0]       o_rdata
);
    import plst_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.re) begin
            o_rdata <= r_mem[i_cmd.raddr];
        end
    end

endmodule

@@ hdl/plst_ctrl.sv @@
// ----------------------------------------------------------------------------
// plst_ctrl: request sequencer
// Checks the position, reads the addressed element of a get or delete, and
// walks the shift one element per cycle, with the read of one entry
// overlapping the write of the previous one.
// ----------------------------------------------------------------------------
module plst_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  plst_pkg::t_req              i_req,
    output logic                        busy,
    output logic                        o_done,
    output plst_pkg::t_rsp              o_rsp,
    output plst_pkg::t_ram_cmd          o_ram_cmd,
    input  logic [plst_pkg::DATA_W-1:0] i_rdata
);
    import plst_pkg::*;

    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_done, n_done;
    logic               r_pend, n_pend;
    t_rsp               r_rsp, n_rsp;
    logic [1:0]         r_func, n_func;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [DATA_W-1:0]  r_val, n_val;
    logic [DATA_W-1:0]  r_data, n_data;
    logic [ADDR_W-1:0]  r_rd, n_rd;
    logic [ADDR_W-1:0]  r_wa, n_wa;
    logic [LEN_W-1:0]   r_left, n_left;

    logic [POS_W-1:0]   pos_m1;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   len_ext;
    logic               in_rng;
    logic               ins_rng;
    logic               accept;

    assign accept  = start && (r_state == S_IDLE);
    assign pos_m1  = r_pos - POS_W'(1);
    assign pos_ext = CMP_W'(r_pos);
    assign len_ext = CMP_W'(r_len);
    assign in_rng  = (r_pos != '0) && (pos_ext <= len_ext);
    assign ins_rng = (r_pos != '0) && (pos_ext <= len_ext + CMP_W'(1));

    // Memory port control. Shift reads and writes never hit the same entry.
    always_comb begin
        o_ram_cmd.re    = ((r_state == S_CHECK) && in_rng &&
                           ((r_func == FN_GET) || (r_func == FN_DEL))) ||
                          ((r_state == S_MOVE) && (r_left != '0));
        o_ram_cmd.raddr = (r_state == S_CHECK) ? pos_m1[ADDR_W-1:0] : r_rd;
        o_ram_cmd.we    = ((r_state == S_MOVE) && r_pend) ||
                          ((r_state == S_FIN) && (r_func == FN_INS));
        o_ram_cmd.waddr = (r_state == S_FIN) ? pos_m1[ADDR_W-1:0] : r_wa;
        o_ram_cmd.wdata = (r_state == S_FIN) ? r_val : i_rdata;
    end

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_done  = 1'b0;
        n_pend  = r_pend;
        n_rsp   = r_rsp;
        n_func  = r_func;
        n_pos   = r_pos;
        n_val   = r_val;
        n_data  = r_data;
        n_rd    = r_rd;
        n_wa    = r_wa;
        n_left  = r_left;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func  = i_req.func;
                    n_pos   = i_req.position;
                    n_val   = i_req.value;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_pend = 1'b0;
                n_rsp  = '{data: '0, status: ST_RANGE, count: CNT_W'(r_len)};
                case (r_func)
                    FN_GET, FN_DEL: begin
                        if (in_rng) begin
                            n_state = S_FETCH;
                        end else begin
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    FN_INS: begin
                        if (!ins_rng) begin
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else if (len_ext == CMP_W'(DEPTH)) begin
                            n_rsp.status = ST_FULL;
                            n_done       = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            // Move entries length-1 down to pos-1 up by one.
                            n_rd    = ADDR_W'(r_len - LEN_W'(1));
                            n_left  = r_len - LEN_W'(pos_m1);
                            n_state = S_MOVE;
                        end
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_FETCH: begin
                n_data = i_rdata;
                if (r_func == FN_GET) begin
                    n_rsp   = '{data: i_rdata, status: ST_OK, count: CNT_W'(r_len)};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    // Move entries pos up to length-1 down by one.
                    n_rd    = r_pos[ADDR_W-1:0];
                    n_left  = r_len - LEN_W'(r_pos);
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                if (r_left != '0) begin
                    n_pend = 1'b1;
                    if (r_func == FN_INS) begin
                        n_wa = r_rd + ADDR_W'(1);
                        n_rd = r_rd - ADDR_W'(1);
                    end else begin
                        n_wa = r_rd - ADDR_W'(1);
                        n_rd = r_rd + ADDR_W'(1);
                    end
                    n_left = r_left - LEN_W'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_func == FN_INS) begin
                    n_len = r_len + LEN_W'(1);
                    n_rsp = '{data: '0, status: ST_OK, count: CNT_W'(r_len + LEN_W'(1))};
                end else begin
                    n_len = r_len - LEN_W'(1);
                    n_rsp = '{data: r_data, status: ST_OK,
                              count: CNT_W'(r_len - LEN_W'(1))};
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_done  <= n_done;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp  <= n_rsp;
        r_func <= n_func;
        r_pos  <= n_pos;
        r_val  <= n_val;
        r_data <= n_data;
        r_rd   <= n_rd;
        r_wa   <= n_wa;
        r_left <= n_left;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking testbench for positional_list_store_core
// Drives get, insert and delete requests through the start/busy handshake,
// keeps its own copy of the ordered store to predict each result, and
// compares every strobed result field by field against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import plst_pkg::*;

    // The unused operation code has no name in the package.
    localparam logic [1:0] FN_NONE = 2'd3;

    // The longest correct busy period and the longest sender gap are both far
    // shorter, so a quiet stretch of this length can only mean a hang.
    localparam int STALL_LIMIT = 2000;
    // Quiet time after the last result, to catch a stray extra strobe.
    localparam int DRAIN_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    positional_list_store_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    // Predictor state: the ordered elements and how many are held.
    logic signed [DATA_W-1:0] list_mem [DEPTH];
    int                       list_len;

    // Results the block still owes, oldest first.
    t_rsp pending_results [$];

    bit mismatch_seen;
    bit gaps_on;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the predictor and return the result it must give.
    // Failed requests leave the store untouched; data is zero unless an
    // element was read or removed.
    function automatic t_rsp apply_list_op(input t_req req);
        t_rsp rsp;
        int   pos;
        int   k;
        pos        = req.position;
        rsp.data   = '0;
        rsp.status = ST_RANGE;
        case (req.func)
            FN_GET: begin
                if (pos >= 1 && pos <= list_len) begin
                    rsp.data   = list_mem[pos-1];
                    rsp.status = ST_OK;
                end
            end
            FN_INS: begin
                // The position check comes first, so a bad position on a
                // full store still reports a range failure.
                if (pos >= 1 && pos <= list_len + 1) begin
                    if (list_len >= DEPTH) begin
                        rsp.status = ST_FULL;
                    end else begin
                        for (k = list_len; k > pos - 1; k--)
                            list_mem[k] = list_mem[k-1];
                        list_mem[pos-1] = req.value;
                        list_len++;
                        rsp.status = ST_OK;
                    end
                end
            end
            FN_DEL: begin
                if (pos >= 1 && pos <= list_len) begin
                    rsp.data = list_mem[pos-1];
                    for (k = pos - 1; k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k+1];
                    list_len--;
                    rsp.status = ST_OK;
                end
            end
            default: begin
                // Unused code: no effect, range status, current count.
            end
        endcase
        rsp.count = list_len[CNT_W-1:0];
        return rsp;
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one, so that a
    // new request shows up at every phase of the shift walk.
    function automatic int next_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 120);
    endfunction

    // Present one request and hold it until the block takes it. While the
    // sender idles, the request bus carries junk that must be ignored.
    // Inputs are written with blocking assignments at the falling edge, a
    // half cycle away from the edge where the block samples them.
    task automatic send_request(input logic [1:0] fn, input int pos,
                                input logic signed [DATA_W-1:0] val);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start          = 1'b0;
            i_req.func     = 2'($urandom);
            i_req.position = POS_W'($urandom);
            i_req.value    = $urandom;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start          = 1'b1;
        i_req.func     = fn;
        i_req.position = pos[POS_W-1:0];
        i_req.value    = val;
        do
            @(posedge i_clk);
        while (busy);
        // Accepted at this edge; predict now, in acceptance order.
        pending_results.push_back(apply_list_op(i_req));
    endtask

    // One random request. ins_pct steers the length up or down. Most
    // positions are in range for the chosen operation so that real shifts
    // happen; the rest cover the whole 9-bit field.
    task automatic send_random_request(input int ins_pct);
        int          roll;
        logic [1:0]  fn;
        int          pos;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            fn = FN_NONE;
        else if (roll < ins_pct)
            fn = FN_INS;
        else if (roll < ins_pct + (100 - ins_pct) / 2)
            fn = FN_DEL;
        else
            fn = FN_GET;
        if ($urandom_range(0, 99) < 10)
            pos = $urandom_range(0, (1 << POS_W) - 1);
        else if (fn == FN_INS)
            pos = $urandom_range(1, list_len + 1);
        else
            pos = $urandom_range(1, (list_len > 0) ? list_len : 1);
        send_request(fn, pos, $urandom);
    endtask

    // Every operation against an empty store, plus position zero, a position
    // with all bits set, and the unused operation code.
    task automatic test_empty_store();
        send_request(FN_GET, 0, 32'sd0);
        send_request(FN_GET, 1, 32'sd0);
        send_request(FN_DEL, 1, 32'sd0);
        send_request(FN_DEL, 511, 32'sd0);
        send_request(FN_INS, 2, 32'sd5);
        send_request(FN_INS, 0, 32'sd5);
        send_request(FN_NONE, 1, 32'sd7);
        send_request(FN_INS, 1, 32'sh7FFF_FFFF);
    endtask

    // Value extremes placed at the front, the end and the middle, then
    // reads and removals at the first, last and just-past-last positions.
    task automatic test_position_edges();
        send_request(FN_INS, list_len + 1, 32'sh8000_0000);
        send_request(FN_INS, 1, -32'sd1);
        send_request(FN_INS, 2, 32'sd0);
        send_request(FN_INS, list_len + 1, 32'shAAAA_AAAA);
        send_request(FN_INS, 3, 32'sh5555_5555);
        send_request(FN_INS, list_len + 2, 32'sd9);
        send_request(FN_GET, 1, 32'sd0);
        send_request(FN_GET, list_len, 32'sd0);
        send_request(FN_GET, list_len + 1, 32'sd0);
        send_request(FN_GET, 511, 32'sd0);
        send_request(FN_NONE, 0, 32'sd0);
        send_request(FN_DEL, 3, 32'sd0);
        send_request(FN_DEL, list_len, 32'sd0);
        send_request(FN_DEL, list_len + 1, 32'sd0);
        send_request(FN_DEL, 1, 32'sd0);
        send_request(FN_GET, 1, 32'sd0);
    endtask

    // Fill the store through random valid positions, hit the full case and
    // its neighbors, work around the top for a while, then drain it.
    task automatic test_full_store();
        int n;
        while (list_len < DEPTH)
            send_request(FN_INS, $urandom_range(1, list_len + 1), $urandom);
        send_request(FN_INS, 1, 32'sd1);
        send_request(FN_INS, list_len + 1, 32'sd1);
        send_request(FN_INS, list_len + 2, 32'sd1);
        send_request(FN_INS, 0, 32'sd1);
        send_request(FN_GET, DEPTH, 32'sd0);
        send_request(FN_GET, DEPTH + 1, 32'sd0);
        send_request(FN_DEL, DEPTH, 32'sd0);
        send_request(FN_INS, DEPTH, 32'sh7FFF_FFFF);
        for (n = 0; n < 60; n++)
            send_random_request((list_len >= DEPTH - 2) ? 40 : 70);
        while (list_len > 0)
            send_request(FN_DEL, $urandom_range(1, list_len), $urandom);
        send_request(FN_GET, 1, 32'sd0);
        send_request(FN_DEL, 1, 32'sd0);
    endtask

    // Long random run in phases that grow, churn and shrink the store, some
    // with sender gaps and some back to back.
    task automatic test_random_mix();
        int phase;
        int n;
        int ins_pct;
        for (phase = 0; phase < 6; phase++) begin
            gaps_on = (phase != 1) && (phase != 4);
            case (phase)
                0, 3:    ins_pct = 60;
                2, 5:    ins_pct = 25;
                default: ins_pct = 40;
            endcase
            for (n = 0; n < 200; n++)
                send_random_request(ins_pct);
        end
        gaps_on = 1'b1;
    endtask

    // Every strobed result is taken at the edge that ends its cycle and
    // compared with the oldest prediction. Outputs are read here, at the
    // rising edge, before the block's own updates of this edge land.
    always @(posedge i_clk) begin : check_results
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: data %0d status %0d count %0d",
                         $time, o_rsp.data, o_rsp.status, o_rsp.count);
                mismatch_seen = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (o_rsp.data !== want.data) begin
                    $display("%0t: data mismatch: expected %0d, actual %0d",
                             $time, want.data, o_rsp.data);
                    mismatch_seen = 1'b1;
                end
                if (o_rsp.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, o_rsp.status);
                    mismatch_seen = 1'b1;
                end
                if (o_rsp.count !== want.count) begin
                    $display("%0t: count mismatch: expected %0d, actual %0d",
                             $time, want.count, o_rsp.count);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // Cycles in which neither a request nor a result went through.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_results.size());
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_req          = '0;
        list_len       = 0;
        mismatch_seen  = 1'b0;
        gaps_on        = 1'b1;
        quiet_cycles   = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_store();
        test_position_edges();
        test_full_store();
        test_random_mix();

        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (!mismatch_seen && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/plst_pkg.sv
hdl/plst_ram.sv
hdl/plst_ctrl.sv
hdl/positional_list_store_core.sv
tb/tb.sv
